/* rtl/output_overcurrent_protector_unit_assert.svh */
// assertion macros shared by the checker
`ifndef OUTPUT_OVERCURRENT_PROTECTOR_UNIT_ASSERT_SVH
`define OUTPUT_OVERCURRENT_PROTECTOR_UNIT_ASSERT_SVH

// property checked on every edge outside reset
`define OCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define OCP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ocp_pkg.sv */
package ocp_pkg;

  // fixed bank size and field widths
  localparam int unsigned MaxOutputs = 8;
  localparam int unsigned ChanW      = 3;
  localparam int unsigned ActW       = 4;
  localparam int unsigned CurW       = 14;
  localparam int unsigned SumW       = 17;
  localparam int unsigned RetryW     = 4;
  localparam int unsigned TripW      = 10;
  localparam int unsigned CntW       = 11;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 17;

  // round sum saturation and total counter limits
  localparam logic [SumW-1:0]        SumMax       = {SumW{1'b1}};
  localparam logic signed [CntW-1:0] CounterWrap  = 11'sd1000;
  localparam logic signed [CntW-1:0] CounterFloor = -11'sd2;
  localparam logic signed [CntW-1:0] CounterRest  = -11'sd1;

  // configuration reset values
  localparam logic [ActW-1:0]   ActiveReset = 4'd8;
  localparam logic [CurW-1:0]   ChanLimReset = 14'd4000;
  localparam logic [SumW-1:0]   TotLimReset  = 17'd8000;
  localparam logic [RetryW-1:0] RetryReset   = 4'd10;
  localparam logic [TripW-1:0]  TripReset    = 10'd120;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_TOGGLE = 2'd2
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_OUTPUTS   = 3'd0,
    REG_CHANNEL_LIMIT_MA = 3'd1,
    REG_TOTAL_LIMIT_MA   = 3'd2,
    REG_RETRY_ROUNDS     = 3'd3,
    REG_TOTAL_TRIP_COUNT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ChanW-1:0] channel;
    logic [CurW-1:0] current_ma;
    logic            level;
    logic            last_in_round;
  } item_t;

  typedef struct packed {
    logic [ActW-1:0]   active_outputs;
    logic [CurW-1:0]   channel_limit_ma;
    logic [SumW-1:0]   total_limit_ma;
    logic [RetryW-1:0] retry_rounds;
    logic [TripW-1:0]  total_trip_count;
  } cfg_t;

  typedef struct packed {
    logic [MaxOutputs-1:0]              user_levels;
    logic [MaxOutputs-1:0]              driven_levels;
    logic [MaxOutputs-1:0][RetryW-1:0]  retry_counts;
    logic [SumW-1:0]                    round_current_sum;
    logic                               round_fault_flag;
    logic signed [CntW-1:0]             total_counter;
  } state_t;

  typedef struct packed {
    logic [MaxOutputs-1:0] drive_levels;
    logic                  channel_tripped;
    logic                  overcurrent_event;
    logic                  total_shutdown;
    logic                  total_restore;
  } result_t;

endpackage

/* rtl/ocp_update.sv */
module ocp_update (
  input  ocp_pkg::item_t  item,
  input  ocp_pkg::cfg_t   cfg,
  input  ocp_pkg::state_t st,
  output ocp_pkg::state_t st_next,
  output ocp_pkg::result_t res
);

  logic [ocp_pkg::ActW-1:0]       act_cnt;
  logic [ocp_pkg::MaxOutputs-1:0] act_mask;
  logic [ocp_pkg::MaxOutputs-1:0] ch_bit;
  logic                           ch_valid;
  logic [ocp_pkg::SumW:0]         sum_wide;
  logic [ocp_pkg::RetryW-1:0]     rc;
  logic signed [ocp_pkg::CntW-1:0] cnt_inc;
  logic [ocp_pkg::MaxOutputs-1:0] user_n;

  // active channel count and mask
  always_comb begin
    act_cnt = (cfg.active_outputs > ocp_pkg::ActW'(ocp_pkg::MaxOutputs)) ?
              ocp_pkg::ActW'(ocp_pkg::MaxOutputs) : cfg.active_outputs;
    for (int i = 0; i < ocp_pkg::MaxOutputs; i++) begin
      act_mask[i] = (ocp_pkg::ActW'(i) < act_cnt);
    end
    ch_valid = ({1'b0, item.channel} < act_cnt);
    ch_bit   = ocp_pkg::MaxOutputs'(1) << item.channel;
    sum_wide = {1'b0, st.round_current_sum} + (ocp_pkg::SumW + 1)'(item.current_ma);
    rc       = st.retry_counts[item.channel];
    cnt_inc  = st.total_counter + 11'sd1;
  end

  // per-item state update
  always_comb begin
    st_next = st;
    res     = '0;
    user_n  = st.user_levels;
    case (ocp_pkg::kind_t'(item.kind))
      ocp_pkg::KIND_WRITE: begin
        if (ch_valid) begin
          user_n = item.level ? (st.user_levels | ch_bit) : (st.user_levels & ~ch_bit);
          st_next.user_levels   = user_n;
          st_next.driven_levels = (st.driven_levels & ~ch_bit) | (user_n & ch_bit);
        end
      end
      ocp_pkg::KIND_TOGGLE: begin
        if (ch_valid) begin
          user_n = st.user_levels ^ ch_bit;
          st_next.user_levels   = user_n;
          st_next.driven_levels = (st.driven_levels & ~ch_bit) | (user_n & ch_bit);
        end
      end
      ocp_pkg::KIND_SAMPLE: begin
        // channel sample: running sum and per-channel cut / retry
        if (ch_valid) begin
          st_next.round_current_sum = sum_wide[ocp_pkg::SumW] ? ocp_pkg::SumMax :
                                      sum_wide[ocp_pkg::SumW-1:0];
          if (item.current_ma > cfg.channel_limit_ma) begin
            st_next.driven_levels = st.driven_levels & ~ch_bit;
            st_next.retry_counts[item.channel] = ocp_pkg::RetryW'(1);
            st_next.round_fault_flag = 1'b1;
            res.channel_tripped = 1'b1;
          end else if (rc != '0 && rc >= cfg.retry_rounds) begin
            st_next.retry_counts[item.channel] = '0;
            st_next.driven_levels = (st.driven_levels & ~ch_bit) |
                                    (st.user_levels & ch_bit);
          end else if (rc != '0) begin
            st_next.retry_counts[item.channel] = rc + ocp_pkg::RetryW'(1);
          end
        end
        // round end: total counter and bank-wide cut / restore
        if (item.last_in_round) begin
          if (st_next.round_current_sum > cfg.total_limit_ma) begin
            st_next.total_counter = (cnt_inc >= ocp_pkg::CounterWrap) ? '0 : cnt_inc;
            st_next.round_fault_flag = 1'b1;
          end else if (st.total_counter > ocp_pkg::CounterFloor) begin
            st_next.total_counter = st.total_counter - 11'sd1;
          end
          res.overcurrent_event = st_next.round_fault_flag;
          if (st_next.total_counter == $signed({1'b0, cfg.total_trip_count})) begin
            st_next.driven_levels = st_next.driven_levels & ~act_mask;
            res.total_shutdown = 1'b1;
          end else if (st_next.total_counter == ocp_pkg::CounterRest) begin
            st_next.driven_levels = (st_next.driven_levels & ~act_mask) |
                                    (st.user_levels & act_mask);
            res.total_restore = 1'b1;
          end
          st_next.round_current_sum = '0;
          st_next.round_fault_flag  = 1'b0;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
    res.drive_levels = st_next.driven_levels;
  end

endmodule

/* rtl/output_overcurrent_protector_unit.sv */
// Overcurrent protector for a bank of eight digital outputs. Each request
// (current sample, level write or toggle) gives exactly one result with the
// driven levels after it and the trip / round flags. One request is taken
// every cycle while in_stall is low; a request is registered in the input
// register on entry, processed in one pass and its result is loaded into
// the output register once that register is free. out_stall holds
// the output register and, through it, the input register, so in_stall
// follows out_stall while both stages are full. The configuration port is
// always ready; write it only while no request is in flight.
module output_overcurrent_protector_unit (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       kind,
  input  logic [ocp_pkg::ChanW-1:0]        channel,
  input  logic [ocp_pkg::CurW-1:0]         current_ma,
  input  logic                             level,
  input  logic                             last_in_round,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ocp_pkg::MaxOutputs-1:0]   drive_levels,
  output logic                             channel_tripped,
  output logic                             overcurrent_event,
  output logic                             total_shutdown,
  output logic                             total_restore,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ocp_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ocp_pkg::CfgDataW-1:0]     cfg_data
);

  ocp_pkg::cfg_t    cfg;
  ocp_pkg::state_t  state;
  ocp_pkg::state_t  state_next;
  ocp_pkg::item_t   item;
  ocp_pkg::result_t res_next;
  ocp_pkg::result_t res;
  logic             item_valid;
  logic             advance;
  logic             accept;

  // handshake
  assign advance   = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_outputs   <= ocp_pkg::ActiveReset;
      cfg.channel_limit_ma <= ocp_pkg::ChanLimReset;
      cfg.total_limit_ma   <= ocp_pkg::TotLimReset;
      cfg.retry_rounds     <= ocp_pkg::RetryReset;
      cfg.total_trip_count <= ocp_pkg::TripReset;
    end else if (cfg_valid && cfg_ready) begin
      case (ocp_pkg::reg_index_t'(cfg_index))
        ocp_pkg::REG_ACTIVE_OUTPUTS:   cfg.active_outputs   <= cfg_data[ocp_pkg::ActW-1:0];
        ocp_pkg::REG_CHANNEL_LIMIT_MA: cfg.channel_limit_ma <= cfg_data[ocp_pkg::CurW-1:0];
        ocp_pkg::REG_TOTAL_LIMIT_MA:   cfg.total_limit_ma   <= cfg_data[ocp_pkg::SumW-1:0];
        ocp_pkg::REG_RETRY_ROUNDS:     cfg.retry_rounds     <= cfg_data[ocp_pkg::RetryW-1:0];
        ocp_pkg::REG_TOTAL_TRIP_COUNT: cfg.total_trip_count <= cfg_data[ocp_pkg::TripW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind          <= kind;
      item.channel       <= channel;
      item.current_ma    <= current_ma;
      item.level         <= level;
      item.last_in_round <= last_in_round;
    end
  end

  // single-pass update
  ocp_update u_update (
    .item    (item),
    .cfg     (cfg),
    .st      (state),
    .st_next (state_next),
    .res     (res_next)
  );

  // protector state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign drive_levels      = res.drive_levels;
  assign channel_tripped   = res.channel_tripped;
  assign overcurrent_event = res.overcurrent_event;
  assign total_shutdown    = res.total_shutdown;
  assign total_restore     = res.total_restore;

endmodule

/* rtl/ocp_checker.sv */
`include "output_overcurrent_protector_unit_assert.svh"

module ocp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ocp_pkg::MaxOutputs-1:0] drive_levels,
  input logic                           channel_tripped,
  input logic                           overcurrent_event,
  input logic                           total_shutdown,
  input logic                           total_restore
);

  // a held result keeps its levels
  `OCP_ASSERT(a_out_hold,
              out_valid && out_stall |=> out_valid && $stable(drive_levels),
              "result changed under stall")

  // one round end cannot both cut and restore the bank
  `OCP_ASSERT(a_shut_rest_excl,
              out_valid |-> !(total_shutdown && total_restore),
              "shutdown and restore together")

  // a channel trip that closes a round marks the round as faulty
  `OCP_ASSERT(a_trip_event,
              out_valid && channel_tripped && (total_shutdown || total_restore)
                |-> overcurrent_event,
              "tripped round end without event")

  // no result leaves right after reset
  `OCP_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind output_overcurrent_protector_unit ocp_checker u_ocp_checker (.*);
